// ===== rtl/core/frame_crc32_validator_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef FRAME_CRC32_VALIDATOR_CORE_ASSERT_SVH
`define FRAME_CRC32_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define FCV_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fcv assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define FCV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fcv assertion failed");

// Next-cycle implication that also watches the reset cycles.
`define FCV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fcv assertion failed");

`endif

// ===== rtl/core/fcv_pkg.sv =====
package fcv_pkg;

    localparam int CNT_W = 4;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [CNT_W-1:0] FIELD_BYTES  = 4'd4;
    localparam logic [CNT_W-1:0] HEADER_BYTES = 4'd8;
    localparam logic [CNT_W-1:0] MIN_FRAME    = 4'd12;

    localparam logic [1:0] FAIL_NONE  = 2'd0;
    localparam logic [1:0] FAIL_SHORT = 2'd1;
    localparam logic [1:0] FAIL_MAGIC = 2'd2;
    localparam logic [1:0] FAIL_CRC   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } fcv_in_t;

    typedef struct packed {
        logic        frame_ok;
        logic [1:0]  fail_code;
        logic [31:0] payload_crc;
    } fcv_out_t;

    // Word held in the input register, handed to the frame checker.
    typedef struct packed {
        logic    valid;
        fcv_in_t item;
    } fcv_stage_t;

    // Reflected CRC-32, one byte per call; flattens to an XOR network.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/frame_crc32_validator_core.sv =====
// Channel  Ports                         Word               Direction
// s_       s_valid s_ready s_data        data_byte,last     in
// m_       m_valid m_ready m_data        ok,code,crc        out
// cfg_     cfg_valid cfg_ready cfg_data  magic_word         in
//
// One byte per cycle sustained unless a last byte waits on a held verdict; each verdict is registered.
// The per-byte CRC update is a combinational XOR network between the input register
// and the frame state; the verdict lands in the output register in the same cycle.
// Reset (aresetn low, synchronous) clears frame state, magic_word and both valids.
// A held verdict stalls the input only once the next last byte sits in the input register.
module frame_crc32_validator_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fcv_pkg::fcv_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fcv_pkg::fcv_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import fcv_pkg::*;

    fcv_stage_t stage;
    fcv_out_t   verdict;
    logic       out_free;
    logic       in_take;
    logic       m_valid_reg;
    logic       m_valid_next;
    fcv_out_t   m_data_reg;
    logic [31:0] magic_word_reg;

    assign out_free = !m_valid_reg || m_ready;
    // a last byte waits for room in the output register
    assign in_take  = stage.valid && (!stage.item.last_byte || out_free);

    fcv_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .take    (in_take),
        .stage   (stage)
    );

    fcv_frame_check u_frame_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (in_take),
        .item       (stage.item),
        .magic_word (magic_word_reg),
        .verdict    (verdict)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            magic_word_reg <= cfg_data;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_take && stage.item.last_byte) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && stage.item.last_byte) begin
            m_data_reg <= verdict;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/fcv_in_reg.sv =====
module fcv_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fcv_pkg::fcv_in_t   s_data,
    input  logic               take,
    output fcv_pkg::fcv_stage_t stage
);
    import fcv_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    fcv_in_t item_reg;

    // Accept a new word when the register is empty or the held one leaves this cycle.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ===== rtl/core/fcv_frame_check.sv =====
module fcv_frame_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  fcv_pkg::fcv_in_t  item,
    input  logic [31:0]       magic_word,
    output fcv_pkg::fcv_out_t verdict
);
    import fcv_pkg::*;

    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic [31:0]      magic_shift_reg;
    logic [31:0]      magic_shift_next;
    logic [31:0]      stored_crc_reg;
    logic [31:0]      stored_crc_next;
    logic [31:0]      crc_accum_reg;
    logic [31:0]      crc_accum_next;
    logic [31:0]      fin_crc;
    logic [1:0]       code;

    // Frame state after this byte, before any end-of-frame clear.
    always_comb begin
        byte_count_next  = byte_count_reg;
        magic_shift_next = magic_shift_reg;
        stored_crc_next  = stored_crc_reg;
        crc_accum_next   = crc_accum_reg;
        if (byte_count_reg < FIELD_BYTES) begin
            magic_shift_next = {magic_shift_reg[23:0], item.data_byte};
        end else if (byte_count_reg < HEADER_BYTES) begin
            stored_crc_next = {stored_crc_reg[23:0], item.data_byte};
        end else begin
            crc_accum_next = crc_byte(crc_accum_reg, item.data_byte);
        end
        // saturate at the minimum frame length
        if (byte_count_reg < MIN_FRAME) begin
            byte_count_next = byte_count_reg + 4'd1;
        end
    end

    assign fin_crc = crc_accum_next ^ CRC_ALL_ONES;

    always_comb begin
        if (byte_count_next < MIN_FRAME) begin
            code = FAIL_SHORT;
        end else if (magic_shift_next != magic_word) begin
            code = FAIL_MAGIC;
        end else if (stored_crc_next != fin_crc) begin
            code = FAIL_CRC;
        end else begin
            code = FAIL_NONE;
        end
    end

    assign verdict.frame_ok    = (code == FAIL_NONE);
    assign verdict.fail_code   = code;
    assign verdict.payload_crc = fin_crc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            magic_shift_reg <= '0;
            stored_crc_reg  <= '0;
            crc_accum_reg   <= CRC_ALL_ONES;
        end else if (step) begin
            if (item.last_byte) begin
                // drop frame state once the verdict is out
                byte_count_reg  <= '0;
                magic_shift_reg <= '0;
                stored_crc_reg  <= '0;
                crc_accum_reg   <= CRC_ALL_ONES;
            end else begin
                byte_count_reg  <= byte_count_next;
                magic_shift_reg <= magic_shift_next;
                stored_crc_reg  <= stored_crc_next;
                crc_accum_reg   <= crc_accum_next;
            end
        end
    end

endmodule

// ===== rtl/core/fcv_checker.sv =====
`include "frame_crc32_validator_core_assert.svh"

module fcv_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input fcv_pkg::fcv_out_t m_data
);
    import fcv_pkg::*;

    logic ok_expected;

    assign ok_expected = (m_data.fail_code == FAIL_NONE);

    `FCV_ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_valid)

    `FCV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    `FCV_ASSERT_NOW(a_ok_matches_code, aclk, aresetn, m_valid, m_data.frame_ok == ok_expected)

    // input only backs up behind a waiting verdict
    `FCV_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready)

endmodule

bind frame_crc32_validator_core fcv_checker u_fcv_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

// ===== tb/tb_top.sv =====
module tb_top;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    fcv_pkg::fcv_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    fcv_pkg::fcv_out_t m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [31:0]       cfg_data = '0;

    // Bytes waiting to be driven and verdicts waiting to be seen.
    fcv_pkg::fcv_in_t  byte_q[$];
    fcv_pkg::fcv_out_t verdict_q[$];
    fcv_pkg::fcv_out_t want_verdict;

    int idle_pct  = 0;
    int stall_pct = 0;
    int errors    = 0;

    // Mirror of the block: register and frame state.
    logic [31:0] magic_reg;
    logic [3:0]  seen_bytes;
    logic [31:0] hdr_magic;
    logic [31:0] hdr_crc;
    logic [31:0] run_crc;

    frame_crc32_validator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bit-serial reflected CRC-32 step over one byte.
    function automatic logic [31:0] crc32_shift_byte(input logic [31:0] crc,
                                                     input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ fcv_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        seen_bytes = '0;
        hdr_magic  = '0;
        hdr_crc    = '0;
        run_crc    = fcv_pkg::CRC_ALL_ONES;
    endtask

    // Advance the frame state by one accepted word; queue a verdict on the last byte.
    task automatic absorb_byte(input fcv_pkg::fcv_in_t w);
        fcv_pkg::fcv_out_t v;
        logic [31:0]       fin;
        logic [1:0]        code;
        if (seen_bytes < fcv_pkg::FIELD_BYTES) begin
            hdr_magic = {hdr_magic[23:0], w.data_byte};
        end else if (seen_bytes < fcv_pkg::HEADER_BYTES) begin
            hdr_crc = {hdr_crc[23:0], w.data_byte};
        end else begin
            run_crc = crc32_shift_byte(run_crc, w.data_byte);
        end
        if (seen_bytes < fcv_pkg::MIN_FRAME) begin
            seen_bytes = seen_bytes + 4'd1;
        end
        if (w.last_byte) begin
            fin = run_crc ^ fcv_pkg::CRC_ALL_ONES;
            if (seen_bytes < fcv_pkg::MIN_FRAME) begin
                code = fcv_pkg::FAIL_SHORT;
            end else if (hdr_magic != magic_reg) begin
                code = fcv_pkg::FAIL_MAGIC;
            end else if (hdr_crc != fin) begin
                code = fcv_pkg::FAIL_CRC;
            end else begin
                code = fcv_pkg::FAIL_NONE;
            end
            v.frame_ok    = (code == fcv_pkg::FAIL_NONE);
            v.fail_code   = code;
            v.payload_crc = fin;
            verdict_q.push_back(v);
            clear_frame_state();
        end
    endtask

    // Build a frame for the current magic; optionally corrupt it or cut it short.
    task automatic queue_frame(input bit bad_magic, input bit bad_crc,
                               input int pay_len, input int cut_len);
        logic [7:0]       fb[$];
        logic [7:0]       b;
        logic [31:0]      mg;
        logic [31:0]      crc;
        fcv_pkg::fcv_in_t w;
        int               n;
        mg  = magic_reg;
        crc = fcv_pkg::CRC_ALL_ONES;
        if (bad_magic) begin
            mg = mg ^ (32'h1 << $urandom_range(31));
        end
        for (int k = 0; k < 4; k++) begin
            fb.push_back(mg[31 - 8*k -: 8]);
        end
        for (int k = 0; k < 4; k++) begin
            fb.push_back(8'h00);
        end
        for (int k = 0; k < pay_len; k++) begin
            b   = 8'($urandom);
            fb.push_back(b);
            crc = crc32_shift_byte(crc, b);
        end
        crc = crc ^ fcv_pkg::CRC_ALL_ONES;
        if (bad_crc) begin
            crc = crc ^ (32'h1 << $urandom_range(31));
        end
        for (int k = 0; k < 4; k++) begin
            fb[4 + k] = crc[31 - 8*k -: 8];
        end
        n = (cut_len > 0 && cut_len < fb.size()) ? cut_len : fb.size();
        for (int k = 0; k < n; k++) begin
            w.data_byte = fb[k];
            w.last_byte = (k == n - 1);
            byte_q.push_back(w);
        end
    endtask

    task automatic queue_noise();
        fcv_pkg::fcv_in_t w;
        int               n;
        n = $urandom_range(1, 30);
        for (int k = 0; k < n; k++) begin
            w.data_byte = 8'($urandom);
            w.last_byte = (k == n - 1);
            byte_q.push_back(w);
        end
    endtask

    task automatic queue_random_frame();
        int r;
        int plen;
        r    = $urandom_range(99);
        plen = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(4, 12);
        if (r < 50) begin
            queue_frame(1'b0, 1'b0, plen, 0);
        end else if (r < 62) begin
            queue_frame(1'b0, 1'b1, plen, 0);
        end else if (r < 72) begin
            queue_frame(1'b1, 1'b0, plen, 0);
        end else if (r < 75) begin
            queue_frame(1'b1, 1'b1, plen, 0);
        end else if (r < 88) begin
            queue_frame(1'b0, 1'b0, plen, $urandom_range(1, 11));
        end else begin
            queue_noise();
        end
    endtask

    // Block until nothing is queued, in flight or expected.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (byte_q.size() != 0 || s_valid || verdict_q.size() != 0);
    endtask

    task automatic write_magic(input logic [31:0] v);
        @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        magic_reg = v;
    endtask

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                idle_pct  = 86;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                idle_pct  = 0;
                stall_pct = 86;
            end
            default: begin
                idle_pct  = 37;
                stall_pct = 37;
            end
        endcase
    endtask

    // Driver: hold the word until accepted, predict on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_byte(s_data);
            end
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_data  <= byte_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted verdict with the oldest one pending.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected verdict ok=%0b code=%0d crc=%08h", $time,
                             m_data.frame_ok, m_data.fail_code, m_data.payload_crc);
                end else begin
                    want_verdict = verdict_q.pop_front();
                    if (m_data.frame_ok !== want_verdict.frame_ok) begin
                        errors++;
                        $display("%0t: frame_ok expected %0b got %0b", $time,
                                 want_verdict.frame_ok, m_data.frame_ok);
                    end
                    if (m_data.fail_code !== want_verdict.fail_code) begin
                        errors++;
                        $display("%0t: fail_code expected %0d got %0d", $time,
                                 want_verdict.fail_code, m_data.fail_code);
                    end
                    if (m_data.payload_crc !== want_verdict.payload_crc) begin
                        errors++;
                        $display("%0t: payload_crc expected %08h got %08h", $time,
                                 want_verdict.payload_crc, m_data.payload_crc);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        logic [31:0] magic_vals[8];
        int          start_len;
        magic_vals[0] = 32'hFFFF_FFFF;
        magic_vals[1] = 32'h0000_0000;
        magic_vals[2] = $urandom;
        magic_vals[3] = 32'h8000_0001;
        magic_vals[4] = $urandom;
        magic_vals[5] = 32'h7FFF_FFFE;
        magic_vals[6] = $urandom;
        magic_vals[7] = $urandom;
        magic_reg = '0;
        clear_frame_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: single-byte frame, bad magic ahead of bad CRC, bad CRC alone.
        set_idle(IDLE_NONE);
        byte_q.push_back('{data_byte: 8'hFF, last_byte: 1'b1});
        queue_frame(1'b1, 1'b1, 4, 0);
        queue_frame(1'b0, 1'b1, 4, 0);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            repeat (4) @(posedge aclk);
            write_magic(magic_vals[p]);
            set_idle(idle_mode_e'(p % 4));
            start_len = 0;
            while (start_len < 204) begin
                start_len -= byte_q.size();
                queue_random_frame();
                start_len += byte_q.size();
                if (p == 5 && start_len >= 100 && start_len < 130) begin
                    // hold the sender until every verdict is in
                    wait_drained();
                    start_len = 130;
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("frame_crc32_validator_core: match");
        end else begin
            $display("frame_crc32_validator_core: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("frame_crc32_validator_core: mismatch");
        $finish;
    end

endmodule

// ===== frame_crc32_validator_core.f =====
+incdir+rtl/core
rtl/core/fcv_pkg.sv
rtl/core/fcv_in_reg.sv
rtl/core/fcv_frame_check.sv
rtl/core/frame_crc32_validator_core.sv
rtl/core/fcv_checker.sv
tb/tb_top.sv
